@@ design/pgc_pkg.sv @@
package pgc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned DistW = 13;
  localparam int unsigned AngleW = 8;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 17;

  localparam logic [CfgAddrW-1:0] CFG_NEAR_THRESHOLD = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_CLOSE_DELAY    = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_OVERRIDE       = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_REPEAT_WINDOW  = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_AUTO_ENABLE    = 3'd4;
  localparam logic [CfgAddrW-1:0] CFG_OPEN_ANGLE     = 3'd5;
  localparam logic [CfgAddrW-1:0] CFG_SHUT_ANGLE     = 3'd6;

  localparam logic [1:0] CMD_OPEN  = 2'd0;
  localparam logic [1:0] CMD_CLOSE = 2'd1;
  localparam logic [1:0] CMD_OTHER = 2'd2;

  localparam logic ACT_SAMPLE = 1'b0;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_OPENED  = 3'd1,
    EV_CLOSED  = 3'd2,
    EV_DUP     = 3'd3,
    EV_EXPIRED = 3'd4
  } ev_t;

  typedef struct packed {
    logic [DistW-1:0]  near_threshold;
    logic [15:0]       close_delay_ms;
    logic [16:0]       override_ms;
    logic [15:0]       repeat_window_ms;
    logic              auto_enable;
    logic [AngleW-1:0] open_angle;
    logic [AngleW-1:0] shut_angle;
  } cfg_t;

  typedef struct packed {
    logic             is_open;
    logic             far_timer_running;
    logic [TimeW-1:0] far_since;
    logic             override_active;
    logic [TimeW-1:0] override_since;
    logic [1:0]       prev_cmd;
    logic             prev_cmd_valid;
    logic [TimeW-1:0] prev_cmd_time;
  } state_t;

  typedef struct packed {
    logic             action;
    logic [TimeW-1:0] now_ms;
    logic [DistW-1:0] distance;
    logic [1:0]       gate_cmd;
  } item_t;

  typedef struct packed {
    logic              gate_open;
    logic [AngleW-1:0] servo_angle;
    ev_t               event_res;
  } result_t;

endpackage

@@ design/pgc_step.sv @@
module pgc_step (
  input  pgc_pkg::cfg_t    cfg,
  input  pgc_pkg::state_t  st,
  input  pgc_pkg::item_t   item,
  output pgc_pkg::state_t  st_nxt,
  output pgc_pkg::result_t res
);
  import pgc_pkg::*;

  logic [TimeW-1:0] elapsed_ovr;
  logic [TimeW-1:0] elapsed_far;
  logic [TimeW-1:0] elapsed_cmd;
  logic [TimeW-1:0] far_elapsed;
  logic [1:0]       cmd_n;
  logic             far;
  ev_t              ev;
  state_t           nx;

  assign elapsed_ovr = item.now_ms - st.override_since;
  assign elapsed_far = item.now_ms - st.far_since;
  assign elapsed_cmd = item.now_ms - st.prev_cmd_time;
  assign far_elapsed = st.far_timer_running ? elapsed_far : '0;
  assign cmd_n = (item.gate_cmd == CMD_OPEN || item.gate_cmd == CMD_CLOSE) ?
                 item.gate_cmd : CMD_OTHER;
  assign far = (item.distance >= cfg.near_threshold) || (item.distance == '0);

  always_comb begin
    nx = st;
    ev = EV_NONE;
    if (item.action == ACT_SAMPLE) begin
      if (st.override_active && (elapsed_ovr >= {15'd0, cfg.override_ms})) begin
        nx.override_active = 1'b0;
        ev = EV_EXPIRED;
      end
      if (!nx.override_active && cfg.auto_enable) begin
        if (!st.is_open && !far) begin
          nx.is_open = 1'b1;
          nx.far_timer_running = 1'b0;
          ev = EV_OPENED;
        end else if (st.is_open) begin
          if (far) begin
            nx.far_timer_running = 1'b1;
            if (!st.far_timer_running) begin
              nx.far_since = item.now_ms;
            end
            if (far_elapsed >= {16'd0, cfg.close_delay_ms}) begin
              nx.is_open = 1'b0;
              nx.far_timer_running = 1'b0;
              ev = EV_CLOSED;
            end
          end else begin
            nx.far_timer_running = 1'b0;
          end
        end
      end
    end else begin
      if (st.prev_cmd_valid && (cmd_n == st.prev_cmd) &&
          (elapsed_cmd < {16'd0, cfg.repeat_window_ms})) begin
        ev = EV_DUP;
      end else begin
        nx.prev_cmd = cmd_n;
        nx.prev_cmd_valid = 1'b1;
        nx.prev_cmd_time = item.now_ms;
        nx.override_active = 1'b1;
        nx.override_since = item.now_ms;
        case (cmd_n)
          CMD_OPEN: begin
            nx.is_open = 1'b1;
            ev = EV_OPENED;
          end
          CMD_CLOSE: begin
            nx.is_open = 1'b0;
            ev = EV_CLOSED;
          end
          default: ev = EV_NONE;
        endcase
      end
    end
  end

  assign st_nxt = nx;
  assign res.gate_open = nx.is_open;
  assign res.servo_angle = nx.is_open ? cfg.open_angle : cfg.shut_angle;
  assign res.event_res = ev;

endmodule

@@ design/proximity_gate_controller.sv @@
// An input transfer is captured in the input register, then one pass of compare
// logic writes its result into the result register.
// Throughput: one item per cycle; the result register and the input register
// advance together whenever the result side is not stalled.
// Reset (rst_n low, synchronous): configuration, state and valid registers return to their defaults,
// gate closed, no override, no timer, no previous command, both stages empty.
module proximity_gate_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_action,
  input  logic [31:0]                     in_now_ms,
  input  logic [12:0]                     in_distance,
  input  logic [1:0]                      in_gate_cmd,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_gate_open,
  output logic [7:0]                      out_servo_angle,
  output logic [2:0]                      out_event_res,
  input  logic                            cfg_we,
  input  logic [pgc_pkg::CfgAddrW-1:0]    cfg_addr,
  input  logic [pgc_pkg::CfgDataW-1:0]    cfg_wdata
);
  import pgc_pkg::*;

  cfg_t    cfg_r;
  state_t  st_r;
  state_t  st_nxt;
  item_t   item_r;
  logic    item_valid_r;
  result_t res_nxt;
  result_t res_r;
  logic    res_valid_r;
  logic    advance;

  assign advance  = !res_valid_r || !out_stall;
  assign in_stall = item_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.near_threshold   <= 13'd400;
      cfg_r.close_delay_ms   <= 16'd3000;
      cfg_r.override_ms      <= 17'd30000;
      cfg_r.repeat_window_ms <= 16'd2000;
      cfg_r.auto_enable      <= 1'b1;
      cfg_r.open_angle       <= 8'd0;
      cfg_r.shut_angle       <= 8'd90;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_NEAR_THRESHOLD: cfg_r.near_threshold   <= cfg_wdata[DistW-1:0];
        CFG_CLOSE_DELAY:    cfg_r.close_delay_ms   <= cfg_wdata[15:0];
        CFG_OVERRIDE:       cfg_r.override_ms      <= cfg_wdata[16:0];
        CFG_REPEAT_WINDOW:  cfg_r.repeat_window_ms <= cfg_wdata[15:0];
        CFG_AUTO_ENABLE:    cfg_r.auto_enable      <= cfg_wdata[0];
        CFG_OPEN_ANGLE:     cfg_r.open_angle       <= cfg_wdata[AngleW-1:0];
        CFG_SHUT_ANGLE:     cfg_r.shut_angle       <= cfg_wdata[AngleW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_r.action   <= in_action;
      item_r.now_ms   <= in_now_ms;
      item_r.distance <= in_distance;
      item_r.gate_cmd <= in_gate_cmd;
    end
  end

  pgc_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
      st_r         <= '0;
    end else begin
      if (!in_stall) begin
        item_valid_r <= in_valid;
      end
      if (advance) begin
        res_valid_r <= item_valid_r;
        if (item_valid_r) begin
          st_r <= st_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = res_valid_r;
  assign out_gate_open   = res_r.gate_open;
  assign out_servo_angle = res_r.servo_angle;
  assign out_event_res   = res_r.event_res;

endmodule
